>>> rtl/clt_pkg.sv
package clt_pkg;

    // Defaults for the top-level parameters.
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    typedef logic [4:0] t_tok_type;

    localparam t_tok_type TT_IDENT      = 5'd0;
    localparam t_tok_type TT_NUMBER     = 5'd1;
    localparam t_tok_type TT_KW_INT     = 5'd2;
    localparam t_tok_type TT_LPAREN     = 5'd9;
    localparam t_tok_type TT_RPAREN     = 5'd10;
    localparam t_tok_type TT_LBRACE     = 5'd11;
    localparam t_tok_type TT_RBRACE     = 5'd12;
    localparam t_tok_type TT_SEMI       = 5'd13;
    localparam t_tok_type TT_COMMA      = 5'd14;
    localparam t_tok_type TT_PLUS       = 5'd15;
    localparam t_tok_type TT_MINUS      = 5'd16;
    localparam t_tok_type TT_STAR       = 5'd17;
    localparam t_tok_type TT_SLASH      = 5'd18;
    localparam t_tok_type TT_BANG       = 5'd19;
    localparam t_tok_type TT_ASSIGN     = 5'd21;
    localparam t_tok_type TT_LESS       = 5'd23;
    localparam t_tok_type TT_GREATER    = 5'd25;
    localparam t_tok_type TT_EOF        = 5'd27;
    localparam t_tok_type TT_ERROR      = 5'd28;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_GT         = 8'h3E;

    // Keywords are held left-justified, first character in the top byte.
    localparam int KW_COUNT   = 7;
    localparam int KW_MAX_LEN = 5;
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        {"int", 16'h0000},
        {"if", 24'h000000},
        {"else", 8'h00},
        "while",
        "print",
        {"true", 8'h00},
        "false"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd4, 3'd5};

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_BANG,
        M_EQ,
        M_LT,
        M_GT,
        M_SLASH,
        M_COMMENT,
        M_HALT
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_char_in;

    typedef struct packed {
        t_tok_type   token_type;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic [7:0]  bad_char;
        logic        last_of_run;
    } t_tok_out;

    // One queue entry carries all results of one input item.
    typedef struct packed {
        logic     two;
        t_tok_out first;
        t_tok_out second;
    } t_entry;

endpackage

>>> rtl/clt_front.sv
module clt_front #(
    parameter int POSITION_BITS = clt_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  clt_pkg::t_char_in i_data,
    output logic              o_push,
    output clt_pkg::t_entry   o_entry
);

    localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;

    clt_pkg::t_scan_mode      r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_cur_line, n_cur_line;
    logic [POSITION_BITS-1:0] r_cur_col, n_cur_col;
    logic [POSITION_BITS-1:0] r_tok_line, n_tok_line;
    logic [POSITION_BITS-1:0] r_tok_col, n_tok_col;
    logic [POSITION_BITS-1:0] r_tok_len, n_tok_len;
    logic [7:0]               r_kw_buf [clt_pkg::KW_MAX_LEN];

    logic [7:0]               c;
    logic                     is_alpha, is_digit, is_space;
    logic                     punct_ok;
    clt_pkg::t_tok_type       punct_t;
    clt_pkg::t_tok_type       kw_type;
    logic                     kw_match;
    clt_pkg::t_tok_type       pend_type;
    logic                     pend_valid;
    logic [POSITION_BITS-1:0] moved_line, moved_col;
    logic                     f_emit, s_emit, restart, do_move;
    clt_pkg::t_tok_out        f_tok, s_tok;
    logic                     kw_we;
    logic [2:0]               kw_idx;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == '1) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] clamp16(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    assign c        = i_data.char_byte;
    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                      || c == clt_pkg::CH_UNDERSCORE;
    assign is_digit = c >= "0" && c <= "9";
    assign is_space = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);

    // Single-character tokens that never wait for a second character.
    always_comb begin
        punct_ok = 1'b1;
        punct_t  = clt_pkg::TT_LPAREN;
        unique case (c)
            "(":     punct_t = clt_pkg::TT_LPAREN;
            ")":     punct_t = clt_pkg::TT_RPAREN;
            "{":     punct_t = clt_pkg::TT_LBRACE;
            "}":     punct_t = clt_pkg::TT_RBRACE;
            ";":     punct_t = clt_pkg::TT_SEMI;
            ",":     punct_t = clt_pkg::TT_COMMA;
            "+":     punct_t = clt_pkg::TT_PLUS;
            "-":     punct_t = clt_pkg::TT_MINUS;
            "*":     punct_t = clt_pkg::TT_STAR;
            default: punct_ok = 1'b0;
        endcase
    end

    // Keyword match of the pending identifier against the buffered prefix.
    always_comb begin
        kw_type  = clt_pkg::TT_IDENT;
        kw_match = 1'b0;
        for (int k = clt_pkg::KW_COUNT - 1; k >= 0; k--) begin
            kw_match = (r_tok_len == POSITION_BITS'(clt_pkg::KW_LEN[k]));
            for (int i = 0; i < clt_pkg::KW_MAX_LEN; i++) begin
                if (i < int'(clt_pkg::KW_LEN[k]) &&
                    r_kw_buf[i] != clt_pkg::KW_TEXT[k][clt_pkg::KW_MAX_LEN*8-1-8*i -: 8]) begin
                    kw_match = 1'b0;
                end
            end
            if (kw_match) begin
                kw_type = clt_pkg::TT_KW_INT + 5'(k);
            end
        end
    end

    always_comb begin
        pend_valid = 1'b1;
        pend_type  = clt_pkg::TT_IDENT;
        unique case (r_mode)
            clt_pkg::M_IDENT:  pend_type = kw_type;
            clt_pkg::M_NUMBER: pend_type = clt_pkg::TT_NUMBER;
            clt_pkg::M_BANG:   pend_type = clt_pkg::TT_BANG;
            clt_pkg::M_EQ:     pend_type = clt_pkg::TT_ASSIGN;
            clt_pkg::M_LT:     pend_type = clt_pkg::TT_LESS;
            clt_pkg::M_GT:     pend_type = clt_pkg::TT_GREATER;
            clt_pkg::M_SLASH:  pend_type = clt_pkg::TT_SLASH;
            default:           pend_valid = 1'b0;
        endcase
    end

    assign moved_line = (c == clt_pkg::CH_NEWLINE) ? sat_inc(r_cur_line) : r_cur_line;
    assign moved_col  = (c == clt_pkg::CH_NEWLINE) ? POS_ONE : sat_inc(r_cur_col);

    always_comb begin
        n_mode     = r_mode;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_tok_len  = r_tok_len;
        f_emit     = 1'b0;
        s_emit     = 1'b0;
        restart    = 1'b0;
        do_move    = 1'b0;
        kw_we      = 1'b0;
        kw_idx     = r_tok_len[2:0];
        f_tok      = '{pend_type, clamp16(r_tok_line), clamp16(r_tok_col),
                       clamp16(r_tok_len), 8'h00, 1'b0};
        s_tok      = '0;

        if (i_accept && i_data.end_of_input) begin
            // Flush whatever token is pending, then EOF; everything restarts.
            f_emit     = pend_valid;
            s_emit     = 1'b1;
            s_tok      = '{clt_pkg::TT_EOF, clamp16(r_cur_line), clamp16(r_cur_col),
                           16'h0000, 8'h00, 1'b0};
            n_mode     = clt_pkg::M_IDLE;
            n_cur_line = POS_ONE;
            n_cur_col  = POS_ONE;
            n_tok_line = POS_ONE;
            n_tok_col  = POS_ONE;
            n_tok_len  = POS_ZERO;
        end else if (i_accept && r_mode != clt_pkg::M_HALT) begin
            unique case (r_mode)
                clt_pkg::M_IDENT: begin
                    if (is_alpha || is_digit) begin
                        kw_we     = r_tok_len < POSITION_BITS'(clt_pkg::KW_MAX_LEN);
                        n_tok_len = sat_inc(r_tok_len);
                        do_move   = 1'b1;
                    end else begin
                        f_emit  = 1'b1;
                        restart = 1'b1;
                    end
                end
                clt_pkg::M_NUMBER: begin
                    if (is_digit) begin
                        n_tok_len = sat_inc(r_tok_len);
                        do_move   = 1'b1;
                    end else begin
                        f_emit  = 1'b1;
                        restart = 1'b1;
                    end
                end
                clt_pkg::M_BANG, clt_pkg::M_EQ, clt_pkg::M_LT, clt_pkg::M_GT: begin
                    if (c == clt_pkg::CH_EQ) begin
                        // The two-character form is the code after the one-character one.
                        s_emit  = 1'b1;
                        s_tok   = '{pend_type + 5'd1, clamp16(r_tok_line), clamp16(r_tok_col),
                                    16'd2, 8'h00, 1'b0};
                        n_mode  = clt_pkg::M_IDLE;
                        do_move = 1'b1;
                    end else begin
                        f_emit  = 1'b1;
                        restart = 1'b1;
                    end
                end
                clt_pkg::M_SLASH: begin
                    if (c == clt_pkg::CH_SLASH) begin
                        n_mode  = clt_pkg::M_COMMENT;
                        do_move = 1'b1;
                    end else begin
                        f_emit  = 1'b1;
                        restart = 1'b1;
                    end
                end
                clt_pkg::M_COMMENT: begin
                    if (c != clt_pkg::CH_NEWLINE) begin
                        do_move = 1'b1;
                    end else begin
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase

            if (restart) begin
                n_mode     = clt_pkg::M_IDLE;
                n_tok_line = r_cur_line;
                n_tok_col  = r_cur_col;
                n_tok_len  = POS_ONE;
                do_move    = 1'b1;
                priority if (is_space) begin
                    n_tok_len = POS_ZERO;
                end else if (is_alpha) begin
                    n_mode = clt_pkg::M_IDENT;
                    kw_we  = 1'b1;
                    kw_idx = 3'd0;
                end else if (is_digit) begin
                    n_mode = clt_pkg::M_NUMBER;
                end else if (punct_ok) begin
                    s_emit = 1'b1;
                    s_tok  = '{punct_t, clamp16(r_cur_line), clamp16(r_cur_col),
                               16'd1, 8'h00, 1'b0};
                end else if (c == clt_pkg::CH_BANG) begin
                    n_mode = clt_pkg::M_BANG;
                end else if (c == clt_pkg::CH_EQ) begin
                    n_mode = clt_pkg::M_EQ;
                end else if (c == clt_pkg::CH_LT) begin
                    n_mode = clt_pkg::M_LT;
                end else if (c == clt_pkg::CH_GT) begin
                    n_mode = clt_pkg::M_GT;
                end else if (c == clt_pkg::CH_SLASH) begin
                    n_mode = clt_pkg::M_SLASH;
                end else begin
                    s_emit = 1'b1;
                    s_tok  = '{clt_pkg::TT_ERROR, clamp16(r_cur_line), clamp16(r_cur_col),
                               16'd1, c, 1'b0};
                    n_mode = clt_pkg::M_HALT;
                end
            end

            if (do_move) begin
                n_cur_line = moved_line;
                n_cur_col  = moved_col;
            end
        end
    end

    always_comb begin
        o_push                     = f_emit || s_emit;
        o_entry.two                = f_emit && s_emit;
        o_entry.first              = f_emit ? f_tok : s_tok;
        o_entry.first.last_of_run  = !(f_emit && s_emit);
        o_entry.second             = s_tok;
        o_entry.second.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= clt_pkg::M_IDLE;
            r_cur_line <= POS_ONE;
            r_cur_col  <= POS_ONE;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_tok_len  <= POS_ZERO;
        end else begin
            r_mode     <= n_mode;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_tok_len  <= n_tok_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (kw_we) begin
            r_kw_buf[kw_idx] <= c;
        end
    end

endmodule

>>> rtl/clt_queue.sv
module clt_queue #(
    parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clt_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output clt_pkg::t_entry o_entry,
    output logic            o_nonempty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    clt_pkg::t_entry  r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full     = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_entry    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> rtl/clt_back.sv
module clt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  clt_pkg::t_entry   i_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output clt_pkg::t_tok_out o_data
);

    logic            r_valid;
    logic            r_second;
    clt_pkg::t_entry r_entry;
    logic            out_done, adv_second;

    // An entry is finished once its last result has been transferred.
    assign out_done   = r_valid && !i_stall && (!r_entry.two || r_second);
    assign adv_second = r_valid && !i_stall && r_entry.two && !r_second;
    assign o_pop      = i_avail && (!r_valid || out_done);
    assign o_valid    = r_valid;
    assign o_data     = r_second ? r_entry.second : r_entry.first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (out_done) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (adv_second) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

endmodule

>>> rtl/c_like_token_lexer_core.sv
// Streaming tokenizer for a small C-like language. Each input transfer carries one source
// byte or an end-of-input mark; each output transfer carries one token with its type,
// start line, start column and length (line and column start at 1 and saturate), plus the
// offending byte for an error token. Whitespace and // comments are skipped, and one byte
// can yield up to two tokens: the pending token it ends and a token of its own. The front
// end accepts one byte every clock cycle while its queue has room; all tokens caused by one
// byte are written as a single queue entry. The back end presents one token per cycle from
// an output register while the receiver does not stall, and the queue of QUEUE_DEPTH entries
// absorbs the bursts of bytes that yield two tokens. After an unexpected byte the lexer emits
// an error token and ignores further bytes until end of input; end of input flushes any
// pending token, emits EOF with last_of_run set, and returns the lexer to its reset state.
module c_like_token_lexer_core #(
    parameter int POSITION_BITS = clt_pkg::POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = clt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  clt_pkg::t_char_in i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output clt_pkg::t_tok_out o_data
);

    logic            in_accept;
    logic            push;
    clt_pkg::t_entry push_entry;
    logic            queue_full;
    logic            pop;
    clt_pkg::t_entry pop_entry;
    logic            queue_nonempty;

    // Input is held off only when the queue cannot take another entry.
    assign o_stall   = queue_full;
    assign in_accept = i_valid && !queue_full;

    // Front end: character classification, scan state and token positions.
    clt_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_data   (i_data),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Decoupling queue between the lexer and the token output.
    clt_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_entry    (pop_entry),
        .o_nonempty (queue_nonempty)
    );

    // Back end: splits each entry into one token transfer per cycle while not stalled.
    clt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (queue_nonempty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

>>> verif/tb_c_like_token_lexer_core.sv
`timescale 1ns / 1ps

module tb_c_like_token_lexer_core;

    localparam logic [15:0] POS_LIMIT   = 16'hFFFF;
    localparam int          REPORT_MAX  = 10;
    localparam int          ITEMS_PHASE = 610;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    clt_pkg::t_char_in          i_data;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    clt_pkg::t_tok_out          o_data;

    c_like_token_lexer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the design stops moving. A correct run of about two thousand
    // bytes with heavy stalls ends well before this limit.
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Idle rates in percent, changed between phases by the main sequence.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int mismatch_count = 0;

    // Tokens the lexer is expected to deliver, oldest first.
    clt_pkg::t_tok_out expected_tokens[$];
    // Tokens produced by the byte currently being lexed.
    clt_pkg::t_tok_out step_tokens[$];

    // Behavioral copy of the lexer state.
    clt_pkg::t_scan_mode lex_mode;
    logic [15:0] src_line;
    logic [15:0] src_col;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] tok_len;
    logic [7:0]  word_buf [5];

    string kw_words [7] = '{"int", "if", "else", "while", "print", "true", "false"};
    string op_words [18] = '{"(", ")", "{", "}", ";", ",", "+", "-", "*", "/",
                             "!", "!=", "=", "==", "<", "<=", ">", ">="};
    logic [7:0] blank_chars [6] = '{8'h20, 8'h09, clt_pkg::CH_NEWLINE, 8'h0B, 8'h0C, 8'h0D};

    //------------------------------------------------------------------------
    // Behavioral lexer
    //------------------------------------------------------------------------

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == POS_LIMIT) ? v : v + 16'd1;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == clt_pkg::CH_UNDERSCORE;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic clt_pkg::t_tok_out make_token(clt_pkg::t_tok_type kind,
                                                     logic [15:0] line,
                                                     logic [15:0] col, logic [15:0] len,
                                                     logic [7:0] bad);
        clt_pkg::t_tok_out tok;
        tok.token_type   = kind;
        tok.start_line   = line;
        tok.start_column = col;
        tok.token_length = len;
        tok.bad_char     = bad;
        tok.last_of_run  = 1'b0;
        return tok;
    endfunction

    // Appends one token to those caused by the current byte.
    task automatic add_step_token(clt_pkg::t_tok_out tok);
        step_tokens = {step_tokens, tok};
    endtask

    // An identifier is a keyword only when its length and every stored byte agree.
    function automatic clt_pkg::t_tok_type classify_word();
        bit same;
        for (int k = 0; k < 7; k++) begin
            if (tok_len == kw_words[k].len()) begin
                same = 1'b1;
                for (int i = 0; i < kw_words[k].len(); i++) begin
                    if (word_buf[i] != kw_words[k][i]) same = 1'b0;
                end
                if (same) return clt_pkg::t_tok_type'(clt_pkg::TT_KW_INT + k);
            end
        end
        return clt_pkg::TT_IDENT;
    endfunction

    function automatic clt_pkg::t_tok_type operator_base(clt_pkg::t_scan_mode m);
        case (m)
            clt_pkg::M_BANG: return clt_pkg::TT_BANG;
            clt_pkg::M_EQ:   return clt_pkg::TT_ASSIGN;
            clt_pkg::M_LT:   return clt_pkg::TT_LESS;
            default:         return clt_pkg::TT_GREATER;
        endcase
    endfunction

    task automatic lexer_clear();
        lex_mode = clt_pkg::M_IDLE;
        src_line = 16'd1;
        src_col  = 16'd1;
        tok_line = 16'd1;
        tok_col  = 16'd1;
        tok_len  = 16'd0;
        foreach (word_buf[i]) word_buf[i] = 8'h00;
    endtask

    // Emits whatever token the current mode holds and falls back to idle.
    task automatic flush_pending();
        case (lex_mode)
            clt_pkg::M_IDENT:
                add_step_token(make_token(classify_word(), tok_line, tok_col, tok_len, 8'h00));
            clt_pkg::M_NUMBER:
                add_step_token(make_token(clt_pkg::TT_NUMBER, tok_line, tok_col, tok_len,
                                          8'h00));
            clt_pkg::M_BANG, clt_pkg::M_EQ, clt_pkg::M_LT, clt_pkg::M_GT:
                add_step_token(make_token(operator_base(lex_mode), tok_line, tok_col,
                                          tok_len, 8'h00));
            clt_pkg::M_SLASH:
                add_step_token(make_token(clt_pkg::TT_SLASH, tok_line, tok_col, tok_len,
                                          8'h00));
            default: ;
        endcase
        lex_mode = clt_pkg::M_IDLE;
    endtask

    // A byte seen from the idle state: it may be skipped as blank, open a token, be a token, or be bad.
    task automatic open_token(logic [7:0] c);
        clt_pkg::t_tok_type single;
        bit                 has_single;
        has_single = 1'b0;
        single     = clt_pkg::TT_IDENT;
        tok_line   = src_line;
        tok_col    = src_col;
        tok_len    = 16'd1;
        if (is_blank(c)) begin
            tok_len = 16'd0;
        end else if (is_letter(c)) begin
            lex_mode    = clt_pkg::M_IDENT;
            word_buf[0] = c;
        end else if (is_digit(c)) begin
            lex_mode = clt_pkg::M_NUMBER;
        end else begin
            has_single = 1'b1;
            case (c)
                "(": single = clt_pkg::TT_LPAREN;
                ")": single = clt_pkg::TT_RPAREN;
                "{": single = clt_pkg::TT_LBRACE;
                "}": single = clt_pkg::TT_RBRACE;
                ";": single = clt_pkg::TT_SEMI;
                ",": single = clt_pkg::TT_COMMA;
                "+": single = clt_pkg::TT_PLUS;
                "-": single = clt_pkg::TT_MINUS;
                "*": single = clt_pkg::TT_STAR;
                clt_pkg::CH_BANG: begin
                    lex_mode = clt_pkg::M_BANG;  has_single = 1'b0;
                end
                clt_pkg::CH_EQ: begin
                    lex_mode = clt_pkg::M_EQ;    has_single = 1'b0;
                end
                clt_pkg::CH_LT: begin
                    lex_mode = clt_pkg::M_LT;    has_single = 1'b0;
                end
                clt_pkg::CH_GT: begin
                    lex_mode = clt_pkg::M_GT;    has_single = 1'b0;
                end
                clt_pkg::CH_SLASH: begin
                    lex_mode = clt_pkg::M_SLASH; has_single = 1'b0;
                end
                default: begin
                    // Anything else is an error and freezes the lexer until end of input.
                    add_step_token(make_token(clt_pkg::TT_ERROR, tok_line, tok_col, 16'd1, c));
                    lex_mode   = clt_pkg::M_HALT;
                    has_single = 1'b0;
                end
            endcase
            if (has_single) add_step_token(make_token(single, tok_line, tok_col, 16'd1, 8'h00));
        end
    endtask

    // Lexes one accepted byte (or end of input) and queues the tokens it causes.
    task automatic lex_predict(logic [7:0] c, logic eoi);
        bit absorbed;
        absorbed = 1'b0;
        step_tokens.delete();
        if (eoi) begin
            if (lex_mode != clt_pkg::M_HALT) flush_pending();
            add_step_token(make_token(clt_pkg::TT_EOF, src_line, src_col, 16'd0, 8'd0));
            lexer_clear();
        end else if (lex_mode != clt_pkg::M_HALT) begin
            case (lex_mode)
                clt_pkg::M_IDENT:
                    if (is_letter(c) || is_digit(c)) begin
                        if (tok_len < 16'd5) word_buf[tok_len[2:0]] = c;
                        tok_len  = sat_inc(tok_len);
                        absorbed = 1'b1;
                    end else begin
                        flush_pending();
                    end
                clt_pkg::M_NUMBER:
                    if (is_digit(c)) begin
                        tok_len  = sat_inc(tok_len);
                        absorbed = 1'b1;
                    end else begin
                        flush_pending();
                    end
                clt_pkg::M_BANG, clt_pkg::M_EQ, clt_pkg::M_LT, clt_pkg::M_GT:
                    if (c == clt_pkg::CH_EQ) begin
                        add_step_token(make_token(operator_base(lex_mode) + 5'd1,
                                                  tok_line, tok_col, 16'd2, 8'h00));
                        lex_mode = clt_pkg::M_IDLE;
                        absorbed = 1'b1;
                    end else begin
                        flush_pending();
                    end
                clt_pkg::M_SLASH:
                    if (c == clt_pkg::CH_SLASH) begin
                        lex_mode = clt_pkg::M_COMMENT;
                        absorbed = 1'b1;
                    end else begin
                        flush_pending();
                    end
                clt_pkg::M_COMMENT:
                    // The newline that ends a comment is handled as plain whitespace.
                    if (c != clt_pkg::CH_NEWLINE) absorbed = 1'b1;
                    else lex_mode = clt_pkg::M_IDLE;
                default:
                    lex_mode = clt_pkg::M_IDLE;
            endcase
            if (!absorbed) open_token(c);
            if (c == clt_pkg::CH_NEWLINE) begin
                src_line = sat_inc(src_line);
                src_col  = 16'd1;
            end else begin
                src_col = sat_inc(src_col);
            end
        end
        if (step_tokens.size() != 0) step_tokens[$].last_of_run = 1'b1;
        expected_tokens = {expected_tokens, step_tokens};
    endtask

    //------------------------------------------------------------------------
    // Output side: random stall and token checking
    //------------------------------------------------------------------------

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    task automatic report_mismatch(string what, clt_pkg::t_tok_out want,
                                   clt_pkg::t_tok_out got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%0t %s: expected type %0d line %0d col %0d len %0d bad %02h last %0b",
                     $realtime, what, want.token_type, want.start_line, want.start_column,
                     want.token_length, want.bad_char, want.last_of_run);
            $display("%0t %s:      got type %0d line %0d col %0d len %0d bad %02h last %0b",
                     $realtime, what, got.token_type, got.start_line, got.start_column,
                     got.token_length, got.bad_char, got.last_of_run);
        end
    endtask

    // A token transfer happens when valid is high and we are not stalling.
    always @(posedge i_clk) begin : check_tokens
        clt_pkg::t_tok_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected token", '0, o_data);
            end else begin
                want = expected_tokens.pop_front();
                if (o_data.token_type   !== want.token_type   ||
                    o_data.start_line   !== want.start_line   ||
                    o_data.start_column !== want.start_column ||
                    o_data.token_length !== want.token_length ||
                    o_data.bad_char     !== want.bad_char     ||
                    o_data.last_of_run  !== want.last_of_run)
                    report_mismatch("token mismatch", want, o_data);
            end
        end
    end

    //------------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after the transfer. Valid is
    // only ever assigned once per edge, so back-to-back bytes keep it high.
    task automatic send_item(logic [7:0] c, logic eoi);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{char_byte: c, end_of_input: eoi};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        lex_predict(c, eoi);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    // The byte that rides along with end of input is ignored, so it is random.
    task automatic send_end();
        send_item(8'($urandom_range(255, 0)), 1'b1);
    endtask

    function automatic logic [7:0] random_word_char(bit first);
        int r;
        r = first ? $urandom_range(52, 0) : $urandom_range(62, 0);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (first || r == 62) return clt_pkg::CH_UNDERSCORE;
        return 8'("0" + r - 52);
    endfunction

    // Sends one random lexeme. Most choices are well formed so that the stream keeps
    // reaching tokens, operators and comments; a rare raw byte exercises the error path.
    task automatic send_random_lexeme();
        int    pick;
        int    n;
        string w;
        logic [7:0] b;
        pick = $urandom_range(99, 0);
        if (pick < 15) begin
            w = kw_words[$urandom_range(6, 0)];
            send_text(w);
            // Sometimes extend a keyword so that it becomes a plain identifier.
            if ($urandom_range(3, 0) == 0) send_item(random_word_char(1'b0), 1'b0);
        end else if (pick < 30) begin
            n = $urandom_range(7, 1);
            send_item(random_word_char(1'b1), 1'b0);
            for (int i = 1; i < n; i++) send_item(random_word_char(1'b0), 1'b0);
        end else if (pick < 40) begin
            n = $urandom_range(5, 1);
            for (int i = 0; i < n; i++) send_item(8'("0" + $urandom_range(9, 0)), 1'b0);
        end else if (pick < 65) begin
            send_text(op_words[$urandom_range(17, 0)]);
        end else if (pick < 80) begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) send_item(blank_chars[$urandom_range(5, 0)], 1'b0);
        end else if (pick < 88) begin
            // Comment bodies carry arbitrary bytes other than newline.
            send_text("//");
            n = $urandom_range(8, 0);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom_range(255, 0));
                if (b == clt_pkg::CH_NEWLINE) b = 8'h80;
                send_item(b, 1'b0);
            end
            if ($urandom_range(4, 0) != 0) send_item(clt_pkg::CH_NEWLINE, 1'b0);
        end else if (pick < 90) begin
            send_item(8'($urandom_range(255, 0)), 1'b0);
        end else begin
            send_item(8'h20, 1'b0);
        end
    endtask

    task automatic send_random_program();
        int lexemes;
        lexemes = $urandom_range(40, 0);
        for (int i = 0; i < lexemes; i++) send_random_lexeme();
        send_end();
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = items_sent + ITEMS_PHASE;
        while (items_sent < stop_at) send_random_program();
    endtask

    //------------------------------------------------------------------------
    // Directed tests
    //------------------------------------------------------------------------

    // Every operator form but a lone '!' and '==', a token ended by the byte after it, a lone
    // slash and a comment that runs to the newline, then end of input flushing a pending '>'.
    task automatic test_operators();
        send_text("x1!=(2)<=y/ //c\n>={};,+-*!==<>");
        send_end();
    endtask

    // Bad bytes at both ends of the byte range. The bytes after an error are ignored
    // and leave the position frozen until end of input.
    task automatic test_error_halt();
        send_item(8'h00, 1'b0);
        send_text("a\n");
        send_end();
        send_text(" ");
        send_item(8'hFF, 1'b0);
        send_item(8'h40, 1'b0);
        send_end();
    endtask

    // Stops sending and waits for every outstanding token, then a little longer so
    // that any stray extra token would still be caught.
    task automatic drain_tokens();
        int waited;
        clt_pkg::t_tok_out left;
        waited  = 0;
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (32) @(posedge i_clk);
        while (expected_tokens.size() != 0) begin
            left = expected_tokens.pop_front();
            report_mismatch("missing token", left, '0);
        end
    endtask

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        lexer_clear();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one: the sender idles now and then, the receiver stalls often.
        send_idle_pct = 24;
        recv_idle_pct = 61;
        test_operators();
        test_error_halt();
        run_random_phase(24, 61);

        // Phase two: the roles swap.
        run_random_phase(61, 24);

        // Phase three: no idling on either side.
        run_random_phase(0, 0);

        drain_tokens();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/clt_pkg.sv
rtl/clt_front.sv
rtl/clt_queue.sv
rtl/clt_back.sv
rtl/c_like_token_lexer_core.sv
verif/tb_c_like_token_lexer_core.sv
